// File: hdl/arcr_pkg.sv
// arcr_pkg: shared types, codes and width helpers of the ARC replacement core
// depends on nothing; every module of the core uses it, the two interfaces do not
package arcr_pkg;

  // default configuration
  localparam int SETS_DEF     = 64;
  localparam int WAYS_DEF     = 16;
  localparam int TAG_BITS_DEF = 48;

  // width of the block_tag field on the input channel
  localparam int TAG_PORT_BITS = 48;

  // entries of the front to back queue
  localparam int QUEUE_DEPTH = 2;

  // operation codes of an input request
  typedef enum logic [1:0] {
    OP_VICTIM = 2'd0,
    OP_FILL   = 2'd1,
    OP_HIT    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // where a victim came from
  typedef enum logic [1:0] {
    SRC_T1       = 2'd0,
    SRC_T2       = 2'd1,
    SRC_INVALID  = 2'd2,
    SRC_FALLBACK = 2'd3
  } src_t;

  // regions of the list memory; the four lists come first so that the low
  // two bits pick their length
  typedef enum logic [2:0] {
    REG_T1   = 3'd0,
    REG_T2   = 3'd1,
    REG_B1   = 3'd2,
    REG_B2   = 3'd3,
    REG_WTAG = 3'd4
  } region_t;

  // what the back does after a list search
  typedef enum logic [1:0] {
    DEC_SEARCH,
    DEC_PUSH,
    DEC_DONE
  } dec_t;

  // back sequencer states
  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_META,
    S_DISP,
    S_ORD_RD,
    S_ORD_WT,
    S_TAG_WT,
    S_WTAG,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_DECIDE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_PUSH_HEAD,
    S_DIV_INIT,
    S_DIV,
    S_ADAPT,
    S_DONE
  } back_state_t;

  // classification the front attaches to each request
  typedef struct packed {
    op_t        op;
    logic       way_ok;
    logic       free_found;
    logic [3:0] free_way;
  } item_ctl_t;

  // status from back to front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // width helpers
  function automatic int set_bits(input int sets);
    return (sets > 1) ? $clog2(sets) : 1;
  endfunction

  function automatic int idx_bits(input int ways);
    return $clog2(ways);
  endfunction

  function automatic int len_bits(input int ways);
    return $clog2(ways + 1);
  endfunction

  function automatic int tag_width(input int tag_bits);
    return (tag_bits < TAG_PORT_BITS) ? tag_bits : TAG_PORT_BITS;
  endfunction

  function automatic int item_bits(input int sets, input int ways, input int tag_bits);
    return $bits(item_ctl_t) + set_bits(sets) + idx_bits(ways) + tag_width(tag_bits);
  endfunction

endpackage

// File: hdl/arcr_in_if.sv
// arcr_in_if: request channel of the ARC replacement core
// depends on nothing
interface arcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  set_index;
  logic [3:0]  way;
  logic [47:0] block_tag;
  logic [15:0] valid_mask;

  modport source (
    output valid, operation, set_index, way, block_tag, valid_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, set_index, way, block_tag, valid_mask,
    output ready
  );
endinterface

// File: hdl/arcr_out_if.sv
// arcr_out_if: result channel of the ARC replacement core
// depends on nothing
interface arcr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] evict_way;
  logic [1:0] victim_source;
  logic [4:0] target_size;
  logic       error;

  modport source (
    output valid, evict_way, victim_source, target_size, error,
    input  ready
  );
  modport sink (
    input  valid, evict_way, victim_source, target_size, error,
    output ready
  );
endinterface

// File: hdl/arcr_front.sv
// arcr_front: accepts requests and classifies them for the back
// depends on arcr_pkg and arcr_in_if
module arcr_front #(
  parameter int SETS     = arcr_pkg::SETS_DEF,
  parameter int WAYS     = arcr_pkg::WAYS_DEF,
  parameter int TAG_BITS = arcr_pkg::TAG_BITS_DEF,
  localparam int SW      = arcr_pkg::set_bits(SETS),
  localparam int WIDX    = arcr_pkg::idx_bits(WAYS),
  localparam int TW      = arcr_pkg::tag_width(TAG_BITS),
  localparam int QW      = arcr_pkg::item_bits(SETS, WAYS, TAG_BITS)
) (
  arcr_in_if.sink              in_ch,
  input  arcr_pkg::back_stat_t stat,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [QW-1:0]        q_data
);

  typedef logic [SW-1:0] set_tab_t [64];

  // set index modulo SETS, worked out at elaboration
  function automatic set_tab_t set_tab_f();
    set_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = SW'(i % SETS);
    end
    return t;
  endfunction

  localparam set_tab_t SET_TAB = set_tab_f();

  arcr_pkg::item_ctl_t ctl;
  logic [SW-1:0]       set_m;

  // accept while the queue has room and the clearing pass is over
  assign in_ch.ready = !q_full && !stat.clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  // lowest way whose valid bit is clear
  always_comb begin
    ctl.op         = arcr_pkg::op_t'(in_ch.operation);
    ctl.way_ok     = (32'(in_ch.way) < WAYS);
    ctl.free_found = 1'b0;
    ctl.free_way   = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (i < WAYS && !in_ch.valid_mask[i]) begin
        ctl.free_found = 1'b1;
        ctl.free_way   = 4'(i);
      end
    end
  end

  assign set_m  = SET_TAB[in_ch.set_index];
  assign q_data = {ctl, set_m, WIDX'(in_ch.way), TW'(in_ch.block_tag)};

endmodule

// File: hdl/arcr_queue.sv
// arcr_queue: short queue of classified requests between front and back
// depends on arcr_pkg
module arcr_queue #(
  parameter int W   = 8,
  localparam int QAW = $clog2(arcr_pkg::QUEUE_DEPTH),
  localparam int QCW = $clog2(arcr_pkg::QUEUE_DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  logic [W-1:0]   ent_r [arcr_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCW'(arcr_pkg::QUEUE_DEPTH));
  assign head  = ent_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(arcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QAW'(arcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

// File: hdl/arcr_back.sv
// arcr_back: sequencer that carries out victim, fill and hit requests on the
// per-set list memory and the per-set length memory; depends on arcr_pkg, arcr_out_if
module arcr_back #(
  parameter int SETS     = arcr_pkg::SETS_DEF,
  parameter int WAYS     = arcr_pkg::WAYS_DEF,
  parameter int TAG_BITS = arcr_pkg::TAG_BITS_DEF,
  localparam int SW      = arcr_pkg::set_bits(SETS),
  localparam int WIDX    = arcr_pkg::idx_bits(WAYS),
  localparam int LW      = arcr_pkg::len_bits(WAYS),
  localparam int TW      = arcr_pkg::tag_width(TAG_BITS),
  localparam int QW      = arcr_pkg::item_bits(SETS, WAYS, TAG_BITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [QW-1:0]        q_data,
  output logic                 q_pop,
  output arcr_pkg::back_stat_t stat,
  arcr_out_if.source           out_ch
);

  localparam int AW    = 3 + SW + WIDX;
  localparam int DEPTH = 5 * (2 ** (SW + WIDX));
  localparam int MTW   = 5 * LW;
  localparam int CTLW  = $bits(arcr_pkg::item_ctl_t);

  // list memory: T1, T2, B1, B2 and way tags, each SETS x WAYS
  logic [TW-1:0]  mem [DEPTH];
  logic [TW-1:0]  rd_q;
  logic [AW-1:0]  mem_raddr, mem_waddr;
  logic           mem_we;
  logic [TW-1:0]  mem_wdata;

  // per-set lengths and target
  logic [MTW-1:0] meta_mem [SETS];
  logic [MTW-1:0] meta_q;
  logic [SW-1:0]  meta_raddr, meta_waddr;
  logic           meta_we;
  logic [MTW-1:0] meta_wdata;

  arcr_pkg::back_state_t state_r, state_nxt;
  logic [SW-1:0]         clr_r, clr_nxt;

  arcr_pkg::item_ctl_t   ctl_r, ctl_nxt;
  logic [SW-1:0]         set_r, set_nxt;
  logic [WIDX-1:0]       way_r, way_nxt;
  logic [TW-1:0]         tag_r, tag_nxt;

  logic [LW-1:0]         lens_r [4];
  logic [LW-1:0]         lens_nxt [4];
  logic [LW-1:0]         p_r, p_nxt;
  arcr_pkg::region_t     region_r, region_nxt;
  logic [LW-1:0]         idx_r, idx_nxt;
  logic [TW-1:0]         key_r, key_nxt;
  logic                  found_r, found_nxt;
  logic                  ghost_hit_r, ghost_hit_nxt;
  logic                  ghost_b2_r, ghost_b2_nxt;
  logic [WIDX-1:0]       vway_r, vway_nxt;
  arcr_pkg::src_t        vsrc_r, vsrc_nxt;
  logic                  err_r, err_nxt;
  logic [LW-1:0]         den_r, den_nxt;
  logic [LW-1:0]         quo_r, quo_nxt;
  logic [LW-1:0]         rem_r, rem_nxt;
  logic [LW-1:0]         dcnt_r, dcnt_nxt;

  logic                  out_valid_r;
  logic [3:0]            out_way_r;
  arcr_pkg::src_t        out_src_r;
  logic [4:0]            out_p_r;
  logic                  out_err_r;

  // decoded helpers
  logic [LW-1:0]         cur_len;
  logic [TW-1:0]         way_key;
  logic                  full_set, take_t1, take_t2, done_fire;
  logic                  cmp_hit;
  arcr_pkg::dec_t        dec;
  arcr_pkg::region_t     dec_reg;
  logic [TW-1:0]         dec_key;
  logic                  dec_ghost, dec_b2, dec_err;
  arcr_pkg::region_t     ghost_reg;
  logic [LW:0]           div_sh;
  logic [LW-1:0]         delta;
  logic [LW:0]           p_sum;

  // length before a push, capped at one below WAYS so that the push leaves at most WAYS
  function automatic logic [LW-1:0] cap_f(input logic [LW-1:0] n);
    return (n >= LW'(WAYS)) ? LW'(WAYS - 1) : n;
  endfunction

  assign stat.clearing = (state_r == arcr_pkg::S_CLR);
  assign cur_len   = lens_r[region_r[1:0]];
  assign way_key   = TW'(way_r);
  assign cmp_hit   = (rd_q == key_r);
  assign done_fire = (state_r == arcr_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  assign ghost_reg = (region_r == arcr_pkg::REG_T1) ? arcr_pkg::REG_B1 : arcr_pkg::REG_B2;

  // victim choice for a full set
  assign full_set = ((LW + 1)'(lens_r[0]) + (LW + 1)'(lens_r[1])) >= (LW + 1)'(WAYS);
  assign take_t1  = full_set && (lens_r[0] != '0) && ((lens_r[0] > p_r) || (lens_r[1] == '0));
  assign take_t2  = full_set && !take_t1 && (lens_r[1] != '0);

  // next step after a search of the list in region_r
  always_comb begin
    dec       = arcr_pkg::DEC_DONE;
    dec_reg   = arcr_pkg::REG_T2;
    dec_key   = way_key;
    dec_ghost = 1'b0;
    dec_b2    = 1'b0;
    dec_err   = 1'b0;
    if (ctl_r.op == arcr_pkg::OP_FILL) begin
      case (region_r)
        arcr_pkg::REG_T1: begin
          dec = arcr_pkg::DEC_SEARCH;
        end
        arcr_pkg::REG_T2: begin
          dec     = arcr_pkg::DEC_SEARCH;
          dec_reg = arcr_pkg::REG_B1;
          dec_key = tag_r;
        end
        arcr_pkg::REG_B1: begin
          if (found_r) begin
            dec       = arcr_pkg::DEC_PUSH;
            dec_ghost = 1'b1;
          end else begin
            dec     = arcr_pkg::DEC_SEARCH;
            dec_reg = arcr_pkg::REG_B2;
            dec_key = tag_r;
          end
        end
        default: begin
          dec = arcr_pkg::DEC_PUSH;
          if (found_r) begin
            dec_ghost = 1'b1;
            dec_b2    = 1'b1;
          end else begin
            dec_reg = arcr_pkg::REG_T1;
          end
        end
      endcase
    end else begin
      case (region_r)
        arcr_pkg::REG_T1: begin
          dec = found_r ? arcr_pkg::DEC_PUSH : arcr_pkg::DEC_SEARCH;
        end
        default: begin
          if (found_r) begin
            dec = arcr_pkg::DEC_PUSH;
          end else begin
            dec_err = 1'b1;
          end
        end
      endcase
    end
  end

  // divider step and target adaptation
  assign div_sh = {rem_r, quo_r[LW-1]};
  assign delta  = (quo_r == '0) ? LW'(1) : quo_r;
  assign p_sum  = (LW + 1)'(p_r) + (LW + 1)'(delta);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arcr_pkg::S_CLR:      if (clr_r == SW'(SETS - 1)) state_nxt = arcr_pkg::S_IDLE;
      arcr_pkg::S_IDLE:     if (!q_empty) state_nxt = arcr_pkg::S_META;
      arcr_pkg::S_META:     state_nxt = arcr_pkg::S_DISP;
      arcr_pkg::S_DISP: begin
        case (ctl_r.op)
          arcr_pkg::OP_VICTIM:
            state_nxt = (take_t1 || take_t2) ? arcr_pkg::S_ORD_RD : arcr_pkg::S_DONE;
          arcr_pkg::OP_FILL:
            state_nxt = ctl_r.way_ok ? arcr_pkg::S_WTAG : arcr_pkg::S_DONE;
          arcr_pkg::OP_HIT:
            state_nxt = ctl_r.way_ok ? arcr_pkg::S_SRCH_RD : arcr_pkg::S_DONE;
          default:
            state_nxt = arcr_pkg::S_DONE;
        endcase
      end
      arcr_pkg::S_ORD_RD:   state_nxt = arcr_pkg::S_ORD_WT;
      arcr_pkg::S_ORD_WT:   state_nxt = arcr_pkg::S_TAG_WT;
      arcr_pkg::S_TAG_WT:   state_nxt = arcr_pkg::S_PUSH_RD;
      arcr_pkg::S_WTAG:     state_nxt = arcr_pkg::S_SRCH_RD;
      arcr_pkg::S_SRCH_RD:
        state_nxt = (idx_r == cur_len) ? arcr_pkg::S_DECIDE : arcr_pkg::S_SRCH_CMP;
      arcr_pkg::S_SRCH_CMP:
        state_nxt = cmp_hit ? arcr_pkg::S_DEL_RD : arcr_pkg::S_SRCH_RD;
      arcr_pkg::S_DEL_RD:
        state_nxt = ((idx_r + 1'b1) >= cur_len) ? arcr_pkg::S_DECIDE : arcr_pkg::S_DEL_WR;
      arcr_pkg::S_DEL_WR:   state_nxt = arcr_pkg::S_DEL_RD;
      arcr_pkg::S_DECIDE: begin
        case (dec)
          arcr_pkg::DEC_SEARCH: state_nxt = arcr_pkg::S_SRCH_RD;
          arcr_pkg::DEC_PUSH:   state_nxt = arcr_pkg::S_PUSH_RD;
          default:              state_nxt = arcr_pkg::S_DONE;
        endcase
      end
      arcr_pkg::S_PUSH_RD:
        state_nxt = (idx_r == '0) ? arcr_pkg::S_PUSH_HEAD : arcr_pkg::S_PUSH_WR;
      arcr_pkg::S_PUSH_WR:  state_nxt = arcr_pkg::S_PUSH_RD;
      arcr_pkg::S_PUSH_HEAD:
        state_nxt = (ctl_r.op == arcr_pkg::OP_FILL && ghost_hit_r) ?
                    arcr_pkg::S_DIV_INIT : arcr_pkg::S_DONE;
      arcr_pkg::S_DIV_INIT: state_nxt = arcr_pkg::S_DIV;
      arcr_pkg::S_DIV:      if (dcnt_r == LW'(1)) state_nxt = arcr_pkg::S_ADAPT;
      arcr_pkg::S_ADAPT:    state_nxt = arcr_pkg::S_DONE;
      arcr_pkg::S_DONE:     if (done_fire) state_nxt = arcr_pkg::S_IDLE;
      default:              state_nxt = arcr_pkg::S_IDLE;
    endcase
  end

  // memory and queue controls
  always_comb begin
    q_pop      = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = rd_q;
    meta_raddr = q_data[TW+WIDX +: SW];
    meta_we    = 1'b0;
    meta_waddr = set_r;
    meta_wdata = {lens_r[3], lens_r[2], lens_r[1], lens_r[0], p_r};
    case (state_r)
      arcr_pkg::S_CLR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
      end
      arcr_pkg::S_IDLE:     q_pop = !q_empty;
      arcr_pkg::S_ORD_RD:   mem_raddr = {region_r, set_r, WIDX'(idx_r)};
      arcr_pkg::S_ORD_WT:   mem_raddr = {arcr_pkg::REG_WTAG, set_r, rd_q[WIDX-1:0]};
      arcr_pkg::S_WTAG: begin
        mem_we    = 1'b1;
        mem_waddr = {arcr_pkg::REG_WTAG, set_r, way_r};
        mem_wdata = tag_r;
      end
      arcr_pkg::S_SRCH_RD:  mem_raddr = {region_r, set_r, WIDX'(idx_r)};
      arcr_pkg::S_DEL_RD:   mem_raddr = {region_r, set_r, WIDX'(idx_r + 1'b1)};
      arcr_pkg::S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {region_r, set_r, WIDX'(idx_r)};
      end
      arcr_pkg::S_PUSH_RD:  mem_raddr = {region_r, set_r, WIDX'(idx_r - 1'b1)};
      arcr_pkg::S_PUSH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {region_r, set_r, WIDX'(idx_r)};
      end
      arcr_pkg::S_PUSH_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = {region_r, set_r, {WIDX{1'b0}}};
        mem_wdata = key_r;
      end
      arcr_pkg::S_DONE:     meta_we = done_fire;
      default: begin
      end
    endcase
  end

  // datapath register updates
  always_comb begin
    clr_nxt       = clr_r;
    ctl_nxt       = ctl_r;
    set_nxt       = set_r;
    way_nxt       = way_r;
    tag_nxt       = tag_r;
    for (int i = 0; i < 4; i++) begin
      lens_nxt[i] = lens_r[i];
    end
    p_nxt         = p_r;
    region_nxt    = region_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    ghost_hit_nxt = ghost_hit_r;
    ghost_b2_nxt  = ghost_b2_r;
    vway_nxt      = vway_r;
    vsrc_nxt      = vsrc_r;
    err_nxt       = err_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    case (state_r)
      arcr_pkg::S_CLR: clr_nxt = clr_r + 1'b1;
      arcr_pkg::S_IDLE: begin
        ctl_nxt       = arcr_pkg::item_ctl_t'(q_data[QW-1 -: CTLW]);
        set_nxt       = q_data[TW+WIDX +: SW];
        way_nxt       = q_data[TW +: WIDX];
        tag_nxt       = q_data[TW-1:0];
        vway_nxt      = '0;
        vsrc_nxt      = arcr_pkg::SRC_T1;
        err_nxt       = 1'b0;
        ghost_hit_nxt = 1'b0;
        ghost_b2_nxt  = 1'b0;
      end
      arcr_pkg::S_META: begin
        p_nxt       = meta_q[LW-1:0];
        lens_nxt[0] = meta_q[LW +: LW];
        lens_nxt[1] = meta_q[2*LW +: LW];
        lens_nxt[2] = meta_q[3*LW +: LW];
        lens_nxt[3] = meta_q[4*LW +: LW];
      end
      arcr_pkg::S_DISP: begin
        case (ctl_r.op)
          arcr_pkg::OP_VICTIM: begin
            if (take_t1) begin
              region_nxt  = arcr_pkg::REG_T1;
              idx_nxt     = lens_r[0] - 1'b1;
              lens_nxt[0] = lens_r[0] - 1'b1;
              vsrc_nxt    = arcr_pkg::SRC_T1;
            end else if (take_t2) begin
              region_nxt  = arcr_pkg::REG_T2;
              idx_nxt     = lens_r[1] - 1'b1;
              lens_nxt[1] = lens_r[1] - 1'b1;
              vsrc_nxt    = arcr_pkg::SRC_T2;
            end else if (ctl_r.free_found) begin
              vway_nxt = WIDX'(ctl_r.free_way);
              vsrc_nxt = arcr_pkg::SRC_INVALID;
            end else begin
              vway_nxt = '0;
              vsrc_nxt = arcr_pkg::SRC_FALLBACK;
            end
          end
          arcr_pkg::OP_HIT: begin
            err_nxt    = !ctl_r.way_ok;
            region_nxt = arcr_pkg::REG_T1;
            key_nxt    = way_key;
            idx_nxt    = '0;
          end
          default: begin
            region_nxt = arcr_pkg::REG_T1;
            key_nxt    = way_key;
            idx_nxt    = '0;
          end
        endcase
      end
      arcr_pkg::S_ORD_WT: vway_nxt = rd_q[WIDX-1:0];
      arcr_pkg::S_TAG_WT: begin
        region_nxt = ghost_reg;
        key_nxt    = rd_q;
        idx_nxt    = cap_f(lens_r[ghost_reg[1:0]]);
      end
      arcr_pkg::S_SRCH_RD: begin
        if (idx_r == cur_len) begin
          found_nxt = 1'b0;
        end
      end
      arcr_pkg::S_SRCH_CMP: begin
        if (cmp_hit) begin
          found_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      arcr_pkg::S_DEL_RD: begin
        if ((idx_r + 1'b1) >= cur_len) begin
          lens_nxt[region_r[1:0]] = cur_len - 1'b1;
        end
      end
      arcr_pkg::S_DEL_WR: idx_nxt = idx_r + 1'b1;
      arcr_pkg::S_DECIDE: begin
        region_nxt    = dec_reg;
        ghost_hit_nxt = dec_ghost;
        ghost_b2_nxt  = dec_b2;
        err_nxt       = dec_err;
        if (dec == arcr_pkg::DEC_PUSH) begin
          key_nxt = way_key;
          idx_nxt = cap_f(lens_r[dec_reg[1:0]]);
        end else begin
          key_nxt = dec_key;
          idx_nxt = '0;
        end
      end
      arcr_pkg::S_PUSH_WR: idx_nxt = idx_r - 1'b1;
      arcr_pkg::S_PUSH_HEAD: lens_nxt[region_r[1:0]] = cap_f(cur_len) + 1'b1;
      arcr_pkg::S_DIV_INIT: begin
        if (ghost_b2_r) begin
          quo_nxt = lens_r[2];
          den_nxt = (lens_r[3] == '0) ? LW'(1) : lens_r[3];
        end else begin
          quo_nxt = lens_r[3];
          den_nxt = (lens_r[2] == '0) ? LW'(1) : lens_r[2];
        end
        rem_nxt  = '0;
        dcnt_nxt = LW'(LW);
      end
      arcr_pkg::S_DIV: begin
        if (div_sh >= (LW + 1)'(den_r)) begin
          rem_nxt = LW'(div_sh - (LW + 1)'(den_r));
          quo_nxt = {quo_r[LW-2:0], 1'b1};
        end else begin
          rem_nxt = LW'(div_sh);
          quo_nxt = {quo_r[LW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 1'b1;
      end
      arcr_pkg::S_ADAPT: begin
        if (ghost_b2_r) begin
          p_nxt = (p_r > delta) ? p_r - delta : '0;
        end else begin
          p_nxt = (p_sum > (LW + 1)'(WAYS)) ? LW'(WAYS) : LW'(p_sum);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arcr_pkg::S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ctl_r       <= ctl_nxt;
    set_r       <= set_nxt;
    way_r       <= way_nxt;
    tag_r       <= tag_nxt;
    for (int i = 0; i < 4; i++) begin
      lens_r[i] <= lens_nxt[i];
    end
    p_r         <= p_nxt;
    region_r    <= region_nxt;
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    ghost_hit_r <= ghost_hit_nxt;
    ghost_b2_r  <= ghost_b2_nxt;
    vway_r      <= vway_nxt;
    vsrc_r      <= vsrc_nxt;
    err_r       <= err_nxt;
    den_r       <= den_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    if (done_fire) begin
      out_way_r <= 4'(vway_r);
      out_src_r <= vsrc_r;
      out_p_r   <= 5'(p_r);
      out_err_r <= err_r;
    end
  end

  // list memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // length memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta_mem[meta_raddr];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.evict_way     = out_way_r;
  assign out_ch.victim_source = out_src_r;
  assign out_ch.target_size   = out_p_r;
  assign out_ch.error         = out_err_r;

  // resident ways never exceed the associativity
  a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arcr_pkg::S_DISP) |-> (lens_r[0] + lens_r[1] <= WAYS))
    else $error("T1 plus T2 longer than the set");

  // target stays within 0..WAYS when a result is formed
  a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arcr_pkg::S_DONE) |-> (p_r <= WAYS))
    else $error("adaptive target out of range");

  // a result only appears out of the completion state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == arcr_pkg::S_DONE))
    else $error("result raised outside completion");

  // no request is taken from the queue and no result is offered while clearing
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arcr_pkg::S_CLR) |-> (!q_pop && !out_valid_r))
    else $error("activity during clearing pass");

endmodule

// File: hdl/arc_cache_replacement_core.sv
// arc_cache_replacement_core: top level of the per-set ARC replacement block
// depends on arcr_pkg, arcr_in_if, arcr_out_if, arcr_front, arcr_queue, arcr_back
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | operation, set_index, way, block_tag, valid_mask
//  out_ch   | out | valid / ready    | evict_way, victim_source, target_size, error
//
// one request at a time in the back; the front and a two-entry queue take
// further requests meanwhile. a victim taken from the valid mask needs only the
// fixed steps; any other request also takes time per list entry searched,
// shifted or moved, per list searched and for the divider when a ghost hit
// adapts p; a fill that scans all four lists of a full set takes longest.
// after reset a clearing pass zeroes the length memory; no request is accepted
// meanwhile. a stalled result holds in the output register while the back
// finishes the next request up to completion.
module arc_cache_replacement_core #(
  parameter int SETS     = arcr_pkg::SETS_DEF,
  parameter int WAYS     = arcr_pkg::WAYS_DEF,
  parameter int TAG_BITS = arcr_pkg::TAG_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  arcr_in_if.sink    in_ch,
  arcr_out_if.source out_ch
);

  localparam int QW = arcr_pkg::item_bits(SETS, WAYS, TAG_BITS);

  arcr_pkg::back_stat_t stat;
  logic                 q_push, q_pop, q_empty, q_full;
  logic [QW-1:0]        q_in, q_head;

  // accept and classify
  arcr_front #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_front (
    .in_ch  (in_ch),
    .stat   (stat),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // decoupling queue
  arcr_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // list sequencer
  arcr_back #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule

// File: dv/arcr_checker.sv
// arcr_checker: watches the request and result channels of the arc replacement core,
// predicts each result from its own per-set arc state and compares field by field
// depends on arcr_pkg, arcr_in_if, arcr_out_if
module arcr_checker (
  input  logic        clk,
  input  logic        rst_n,
  arcr_in_if.sink     in_mon,
  arcr_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam int NSETS = 64;
  localparam int NWAYS = 16;

  typedef struct packed {
    logic [3:0]     evict_way;
    arcr_pkg::src_t victim_source;
    logic [4:0]     target_size;
    logic           error;
  } arc_result_t;

  // per-set arc state
  logic [3:0]  t1_list [NSETS][NWAYS];
  logic [3:0]  t2_list [NSETS][NWAYS];
  logic [47:0] b1_list [NSETS][NWAYS];
  logic [47:0] b2_list [NSETS][NWAYS];
  logic [47:0] tag_of  [NSETS][NWAYS];
  int          t1_n [NSETS];
  int          t2_n [NSETS];
  int          b1_n [NSETS];
  int          b2_n [NSETS];
  int          p_tgt [NSETS];

  arc_result_t expected_results [$];

  // remove way at position from a way list
  function automatic void drop_way(int s, bit second, int pos);
    int i;
    if (!second) begin
      for (i = pos; i < t1_n[s] - 1; i++) t1_list[s][i] = t1_list[s][i+1];
      t1_n[s]--;
    end else begin
      for (i = pos; i < t2_n[s] - 1; i++) t2_list[s][i] = t2_list[s][i+1];
      t2_n[s]--;
    end
  endfunction

  function automatic void push_t2(int s, logic [3:0] w);
    int i;
    int n;
    n = (t2_n[s] >= NWAYS) ? NWAYS - 1 : t2_n[s];
    for (i = n; i > 0; i--) t2_list[s][i] = t2_list[s][i-1];
    t2_list[s][0] = w;
    t2_n[s] = n + 1;
  endfunction

  function automatic void push_ghost(int s, bit second, logic [47:0] tg);
    int i;
    int n;
    n = second ? b2_n[s] : b1_n[s];
    if (n >= NWAYS) n = NWAYS - 1;
    for (i = n; i > 0; i--) begin
      if (second) b2_list[s][i] = b2_list[s][i-1];
      else        b1_list[s][i] = b1_list[s][i-1];
    end
    if (second) begin b2_list[s][0] = tg; b2_n[s] = n + 1; end
    else begin b1_list[s][0] = tg; b1_n[s] = n + 1; end
  endfunction

  function automatic void drop_ghost(int s, bit second, int pos);
    int i;
    if (!second) begin
      for (i = pos; i < b1_n[s] - 1; i++) b1_list[s][i] = b1_list[s][i+1];
      b1_n[s]--;
    end else begin
      for (i = pos; i < b2_n[s] - 1; i++) b2_list[s][i] = b2_list[s][i+1];
      b2_n[s]--;
    end
  endfunction

  // step the arc state for one request and return the result it causes
  function automatic arc_result_t arc_predict(arcr_pkg::op_t op, int s, logic [3:0] w,
                                              logic [47:0] tg, logic [15:0] vm);
    arc_result_t r;
    int i;
    int pos;
    int d;
    int den;
    logic [3:0] v;
    bit done;
    r = '0;
    r.victim_source = arcr_pkg::SRC_T1;
    done = 0;
    case (op)
      arcr_pkg::OP_VICTIM: begin
        if (t1_n[s] + t2_n[s] >= NWAYS) begin
          if (t1_n[s] > 0 && (t1_n[s] > p_tgt[s] || t2_n[s] == 0)) begin
            v = t1_list[s][t1_n[s]-1];
            t1_n[s]--;
            push_ghost(s, 0, tag_of[s][v]);
            r.evict_way = v;
            r.victim_source = arcr_pkg::SRC_T1;
            done = 1;
          end else if (t2_n[s] > 0) begin
            v = t2_list[s][t2_n[s]-1];
            t2_n[s]--;
            push_ghost(s, 1, tag_of[s][v]);
            r.evict_way = v;
            r.victim_source = arcr_pkg::SRC_T2;
            done = 1;
          end
        end
        if (!done) begin
          r.evict_way = 0;
          r.victim_source = arcr_pkg::SRC_FALLBACK;
          for (i = NWAYS - 1; i >= 0; i--)
            if (!vm[i]) begin
              r.evict_way = i[3:0];
              r.victim_source = arcr_pkg::SRC_INVALID;
            end
        end
      end
      arcr_pkg::OP_FILL: begin
        tag_of[s][w] = tg;
        for (i = 0; i < t1_n[s]; i++) if (t1_list[s][i] == w) begin drop_way(s, 0, i); break; end
        for (i = 0; i < t2_n[s]; i++) if (t2_list[s][i] == w) begin drop_way(s, 1, i); break; end
        pos = -1;
        for (i = 0; i < b1_n[s]; i++) if (b1_list[s][i] == tg) begin pos = i; break; end
        if (pos >= 0) begin
          drop_ghost(s, 0, pos);
          push_t2(s, w);
          den = (b1_n[s] != 0) ? b1_n[s] : 1;
          d = b2_n[s] / den;
          if (d < 1) d = 1;
          p_tgt[s] = (p_tgt[s] + d > NWAYS) ? NWAYS : p_tgt[s] + d;
        end else begin
          for (i = 0; i < b2_n[s]; i++) if (b2_list[s][i] == tg) begin pos = i; break; end
          if (pos >= 0) begin
            drop_ghost(s, 1, pos);
            push_t2(s, w);
            den = (b2_n[s] != 0) ? b2_n[s] : 1;
            d = b1_n[s] / den;
            if (d < 1) d = 1;
            p_tgt[s] = (p_tgt[s] > d) ? p_tgt[s] - d : 0;
          end else begin
            for (i = t1_n[s]; i > 0; i--) t1_list[s][i] = t1_list[s][i-1];
            t1_list[s][0] = w;
            t1_n[s]++;
          end
        end
      end
      arcr_pkg::OP_HIT: begin
        pos = -1;
        for (i = 0; i < t1_n[s]; i++) if (t1_list[s][i] == w) begin pos = i; break; end
        if (pos >= 0) begin
          drop_way(s, 0, pos);
          push_t2(s, w);
        end else begin
          for (i = 0; i < t2_n[s]; i++) if (t2_list[s][i] == w) begin pos = i; break; end
          if (pos >= 0) begin
            drop_way(s, 1, pos);
            push_t2(s, w);
          end
        end
        if (pos < 0) r.error = 1'b1;
      end
      default: ;
    endcase
    r.target_size = p_tgt[s][4:0];
    return r;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    arc_result_t got;
    arc_result_t exp_r;
    if (!rst_n) begin
      for (int s = 0; s < NSETS; s++) begin
        t1_n[s] = 0; t2_n[s] = 0; b1_n[s] = 0; b2_n[s] = 0; p_tgt[s] = 0;
      end
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.evict_way = out_mon.evict_way;
        got.victim_source = arcr_pkg::src_t'(out_mon.victim_source);
        got.target_size = out_mon.target_size;
        got.error = out_mon.error;
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(arc_predict(arcr_pkg::op_t'(in_mon.operation),
          int'(in_mon.set_index), in_mon.way, in_mon.block_tag, in_mon.valid_mask));
      pending_count <= expected_results.size();
    end
  end
endmodule

// File: dv/arc_cache_replacement_core_tb.sv
// arc_cache_replacement_core_tb: stimulus and verdict for the arc replacement core
// depends on arcr_pkg, arcr_in_if, arcr_out_if, arcr_checker and the core
module arc_cache_replacement_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   result_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  bit   hold_go;
  bit   hold_done;
  int   quiet_cycles;
  int   sent_count;

  arcr_in_if  in_ch ();
  arcr_out_if out_ch ();

  arc_cache_replacement_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  arcr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch.sink),
    .out_mon       (out_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // one request; sender idles at random before offering it
  task automatic send_request(arcr_pkg::op_t op, logic [5:0] s, logic [3:0] w,
                              logic [47:0] tg, logic [15:0] vm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.set_index  <= s;
    in_ch.way        <= w;
    in_ch.block_tag  <= tg;
    in_ch.valid_mask <= vm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // random victim, fill, hit and unknown-op requests, mostly on sets 0 to 3
  task automatic arc_traffic(int count);
    logic [5:0] s;
    logic [3:0] w;
    logic [47:0] tg;
    int r;
    for (int n = 0; n < count; n++) begin
      s = 6'($urandom_range(3));
      if ($urandom_range(9) == 0) s = 6'($urandom);
      w = 4'($urandom);
      tg = 48'({$urandom_range(40), $urandom_range(3)} * 48'h0123_4567_89ab);
      if ($urandom_range(15) == 0) tg = 48'({$urandom, $urandom});
      r = $urandom_range(99);
      if (r < 30) send_request(arcr_pkg::OP_VICTIM, s, w, tg, 16'($urandom) | 16'($urandom));
      else if (r < 65) send_request(arcr_pkg::OP_FILL, s, w, tg, 16'($urandom));
      else if (r < 96) send_request(arcr_pkg::OP_HIT, s, w, tg, 16'($urandom));
      else send_request(arcr_pkg::OP_NONE, s, w, tg, 16'($urandom));
    end
  endtask

  // receiver: random idling plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= 0;
      hold_done    <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cycles  <= 1500;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = arcr_pkg::OP_VICTIM;
    in_ch.set_index = '0;
    in_ch.way = '0;
    in_ch.block_tag = '0;
    in_ch.valid_mask = '0;
    hold_go = 1'b0;
    sent_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-set victims, field extremes, error hits, unknown op
    send_request(arcr_pkg::OP_VICTIM, 6'd0, 4'd0, 48'h0, 16'h0000);
    send_request(arcr_pkg::OP_VICTIM, 6'd63, 4'd15, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_request(arcr_pkg::OP_VICTIM, 6'd1, 4'd0, 48'h0, 16'h7FFF);
    send_request(arcr_pkg::OP_HIT, 6'd0, 4'd3, 48'h0, 16'h0);
    send_request(arcr_pkg::OP_NONE, 6'd63, 4'd15, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    // fill set 5 fully, refill one way, hit in T1 and T2
    for (int i = 0; i < 16; i++)
      send_request(arcr_pkg::OP_FILL, 6'd5, 4'(i), 48'(i) | 48'hA000_0000_0000, 16'h0);
    send_request(arcr_pkg::OP_FILL, 6'd5, 4'd2, 48'hFFFF_FFFF_FFFF, 16'h0);
    send_request(arcr_pkg::OP_HIT, 6'd5, 4'd15, 48'h0, 16'h0);
    send_request(arcr_pkg::OP_HIT, 6'd5, 4'd15, 48'h0, 16'h0);
    // evict from the full set, then ghost fill back
    send_request(arcr_pkg::OP_VICTIM, 6'd5, 4'd0, 48'h0, 16'hFFFF);
    send_request(arcr_pkg::OP_FILL, 6'd5, 4'd0, 48'hA000_0000_0000, 16'h0);

    // random phases with different idling
    send_idle_pct = 17; recv_idle_pct = 80;
    arc_traffic(430);
    send_idle_pct = 80; recv_idle_pct = 17;
    arc_traffic(430);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_go = 1'b1;
    arc_traffic(440);
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests, checked %0d results across victim, fill and hit traffic",
             sent_count, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
